/* src/packet_sequence_offset_checker_defines.svh */
// Assertion macros for the packet sequence offset checker.
`ifndef PACKET_SEQUENCE_OFFSET_CHECKER_DEFINES_SVH
`define PACKET_SEQUENCE_OFFSET_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define PSOC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("psoc assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define PSOC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("psoc assertion failed");

`endif

/* src/psoc_pkg.sv */
// Shared types and constants for the packet sequence offset checker.
package psoc_pkg;

    localparam int SEQ_W       = 64;
    localparam int DIV_ITER    = SEQ_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_ITER);
    localparam int START_LIMIT = 10;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [0:0] REG_DIST_INDEX = 1'b0;
    localparam logic [0:0] REG_DIST_COUNT = 1'b1;

    localparam logic [1:0] STATUS_NORMAL = 2'd0;
    localparam logic [1:0] STATUS_GAP    = 2'd1;
    localparam logic [1:0] STATUS_START  = 2'd2;

    typedef struct packed {
        logic [1:0] index;
        logic [2:0] count;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_ADJ  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

endpackage

/* src/packet_sequence_offset_checker.sv */
// Top level: packet sequence offset checker with shared iterative divider.
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    s_raw_sequence
//  m_        out  m_valid/m_ready    m_sequence_number, m_status, m_offset_adjusted,
//                                    m_global_offset_now, m_first_packet
//  apb       in   psel/penable       paddr, pwdata, prdata (index 0x0, count 0x4)
//
// An item passes through the divider once when the offset holds and twice when
// it moves; the shared divider retires two quotient bits per cycle.
// Reset is synchronous on aresetn; offset resets to all ones.
// A result held by m_ready low stalls only the final load; the next item may
// be accepted while the previous result waits.
`include "packet_sequence_offset_checker_defines.svh"

module packet_sequence_offset_checker #(
    parameter int SEQUENCE_STRIDE  = 1024,
    parameter int MAX_DISTRIBUTORS = 4
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [psoc_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [psoc_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [psoc_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [63:0]                             s_raw_sequence,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [63:0]                             m_sequence_number,
    output logic [1:0]                              m_status,
    output logic                                    m_offset_adjusted,
    output logic signed [63:0]                      m_global_offset_now,
    output logic                                    m_first_packet
);

    localparam int MOD_W  = $clog2(SEQUENCE_STRIDE * MAX_DISTRIBUTORS + 1);
    localparam int BASE_W = $clog2(SEQUENCE_STRIDE * 3 + 1);
    localparam int SEQ_W  = psoc_pkg::SEQ_W;

    psoc_pkg::cfg_t   cfg;
    psoc_pkg::state_t state_reg, state_next;

    logic [SEQ_W-1:0] raw_reg, raw_next;
    logic [SEQ_W-1:0] offset_reg, offset_next;
    logic [SEQ_W-1:0] prev_reg, prev_next;
    logic [SEQ_W-1:0] first_seq_reg, first_seq_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic             adj_reg, adj_next;

    logic             m_valid_reg, m_valid_next;
    logic [SEQ_W-1:0] m_seq_reg, m_seq_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic             m_adj_reg, m_adj_next;
    logic [SEQ_W-1:0] m_off_reg, m_off_next;
    logic             m_first_reg, m_first_next;

    logic [2:0]        eff_count;
    logic [MOD_W-1:0]  modulus;
    logic [BASE_W-1:0] base;
    logic [SEQ_W-1:0]  sum;
    logic [SEQ_W-1:0]  rem_ext;
    logic [SEQ_W-1:0]  up_step;
    logic [SEQ_W-1:0]  val_adj;
    logic              go_down;

    logic              div_start, div_busy, div_done;
    logic [SEQ_W-1:0]  div_dividend, div_quo;
    logic [MOD_W-1:0]  div_rem;

    logic              rem_zero, gap, near_start, out_load;
    logic [1:0]        status;

    psoc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    psoc_div #(
        .DIV_W (MOD_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (mod_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign pready  = 1'b1;
    assign s_ready = (state_reg == psoc_pkg::ST_IDLE);

    always_comb begin
        if (cfg.count < 3'd2) begin
            eff_count = 3'd2;
        end else if (int'(cfg.count) > MAX_DISTRIBUTORS) begin
            eff_count = 3'(MAX_DISTRIBUTORS);
        end else begin
            eff_count = cfg.count;
        end
    end

    assign modulus = MOD_W'(SEQUENCE_STRIDE) * MOD_W'(eff_count);
    assign base    = BASE_W'(SEQUENCE_STRIDE) * BASE_W'(cfg.index);
    assign sum     = raw_reg + offset_reg - SEQ_W'(base);

    // nearest multiple of the modulus: down below half, up otherwise
    assign rem_ext = SEQ_W'(div_rem);
    assign up_step = SEQ_W'(mod_reg - div_rem);
    assign go_down = div_rem < (mod_reg >> 1);
    assign val_adj = go_down ? raw_reg + (offset_reg - rem_ext) - SEQ_W'(base)
                             : raw_reg + (offset_reg + up_step) - SEQ_W'(base);

    assign div_start    = (state_reg == psoc_pkg::ST_SUM) || (state_reg == psoc_pkg::ST_ADJ);
    assign div_dividend = (state_reg == psoc_pkg::ST_SUM) ? sum : val_adj;

    assign rem_zero   = (div_rem == '0);
    assign gap        = (prev_reg != '0) && ((div_quo - prev_reg) != SEQ_W'(1));
    assign near_start = div_quo[SEQ_W-1] || (div_quo < SEQ_W'(psoc_pkg::START_LIMIT));

    always_comb begin
        if (!rem_zero) begin
            status = psoc_pkg::STATUS_NORMAL;
        end else if (gap) begin
            status = psoc_pkg::STATUS_GAP;
        end else if (near_start) begin
            status = psoc_pkg::STATUS_START;
        end else begin
            status = psoc_pkg::STATUS_NORMAL;
        end
    end

    assign out_load = (state_reg == psoc_pkg::ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        offset_next    = offset_reg;
        prev_next      = prev_reg;
        first_seq_next = first_seq_reg;
        mod_next       = mod_reg;
        adj_next       = adj_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_seq_next     = m_seq_reg;
        m_status_next  = m_status_reg;
        m_adj_next     = m_adj_reg;
        m_off_next     = m_off_reg;
        m_first_next   = m_first_reg;
        case (state_reg)
            psoc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    raw_next   = s_raw_sequence;
                    mod_next   = modulus;
                    adj_next   = 1'b0;
                    state_next = psoc_pkg::ST_SUM;
                end
            end
            psoc_pkg::ST_SUM: begin
                state_next = psoc_pkg::ST_DIV;
            end
            psoc_pkg::ST_DIV: begin
                if (div_done) begin
                    if (!rem_zero && !adj_reg) begin
                        state_next = psoc_pkg::ST_ADJ;
                    end else begin
                        state_next = psoc_pkg::ST_FIN;
                    end
                end
            end
            psoc_pkg::ST_ADJ: begin
                adj_next    = 1'b1;
                offset_next = go_down ? offset_reg - rem_ext : offset_reg + up_step;
                state_next  = psoc_pkg::ST_DIV;
            end
            psoc_pkg::ST_FIN: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    m_seq_next    = div_quo;
                    m_status_next = status;
                    m_adj_next    = adj_reg;
                    m_off_next    = offset_reg;
                    m_first_next  = (first_seq_reg == '0);
                    prev_next     = div_quo;
                    if (first_seq_reg == '0) begin
                        first_seq_next = div_quo;
                    end
                    state_next = psoc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psoc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= psoc_pkg::ST_IDLE;
            offset_reg    <= '1;
            prev_reg      <= '0;
            first_seq_reg <= '0;
            adj_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            prev_reg      <= prev_next;
            first_seq_reg <= first_seq_next;
            adj_reg       <= adj_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg      <= raw_next;
        mod_reg      <= mod_next;
        m_seq_reg    <= m_seq_next;
        m_status_reg <= m_status_next;
        m_adj_reg    <= m_adj_next;
        m_off_reg    <= m_off_next;
        m_first_reg  <= m_first_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_sequence_number   = m_seq_reg;
    assign m_status            = m_status_reg;
    assign m_offset_adjusted   = m_adj_reg;
    assign m_global_offset_now = m_off_reg;
    assign m_first_packet      = m_first_reg;

    `PSOC_ASSERT_SAME(a_ready_div_idle, s_ready, !div_busy)
    `PSOC_ASSERT_SAME(a_done_in_div, div_done, state_reg == psoc_pkg::ST_DIV)
    `PSOC_ASSERT_NEXT(a_fin_loads, (state_reg == psoc_pkg::ST_FIN) && !m_valid_reg, m_valid_reg)

endmodule

/* src/psoc_cfg.sv */
// APB configuration registers: distributor index and distributor count.
module psoc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psoc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [psoc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [psoc_pkg::APB_DATA_W-1:0]     prdata,
    output psoc_pkg::cfg_t                      cfg
);

    logic [1:0] index_reg, index_next;
    logic [2:0] count_reg, count_next;
    logic [0:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        index_next = index_reg;
        count_next = count_reg;
        prdata     = '0;
        case (reg_sel)
            psoc_pkg::REG_DIST_INDEX: begin
                prdata = psoc_pkg::APB_DATA_W'(index_reg);
                if (wr_en) begin
                    index_next = pwdata[1:0];
                end
            end
            psoc_pkg::REG_DIST_COUNT: begin
                prdata = psoc_pkg::APB_DATA_W'(count_reg);
                if (wr_en) begin
                    count_next = pwdata[2:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= 2'd0;
            count_reg <= 3'd2;
        end else begin
            index_reg <= index_next;
            count_reg <= count_next;
        end
    end

    assign cfg.index = index_reg;
    assign cfg.count = count_reg;

endmodule

/* src/psoc_div.sv */
// Shared radix-4 restoring divider: 64-bit dividend, narrow divisor.
module psoc_div #(
    parameter int DIV_W = 21
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [psoc_pkg::SEQ_W-1:0]  dividend,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        busy,
    output logic                        done,
    output logic [psoc_pkg::SEQ_W-1:0]  quotient,
    output logic [DIV_W-1:0]            remainder
);

    logic [psoc_pkg::SEQ_W-1:0]     acc_reg, acc_next;
    logic [DIV_W-1:0]               rem_reg, rem_next;
    logic [DIV_W-1:0]               dvs_reg, dvs_next;
    logic [psoc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [DIV_W:0] r1, r1s, r2, r2s;
    logic           q1, q2;

    // two quotient bits per cycle
    always_comb begin
        r1  = {rem_reg, acc_reg[psoc_pkg::SEQ_W-1]};
        q1  = r1 >= {1'b0, dvs_reg};
        r1s = q1 ? r1 - {1'b0, dvs_reg} : r1;
        r2  = {r1s[DIV_W-1:0], acc_reg[psoc_pkg::SEQ_W-2]};
        q2  = r2 >= {1'b0, dvs_reg};
        r2s = q2 ? r2 - {1'b0, dvs_reg} : r2;
    end

    always_comb begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = {acc_reg[psoc_pkg::SEQ_W-3:0], q1, q2};
            rem_next = r2s[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == psoc_pkg::DIV_CNT_W'(psoc_pkg::DIV_ITER - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = acc_reg;
    assign remainder = rem_reg;

endmodule
